// ----- src/remote_enable_gate_fsm_defines.svh -----
// Assertion macros for the remote enable gate.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef REMOTE_ENABLE_GATE_FSM_DEFINES_SVH
`define REMOTE_ENABLE_GATE_FSM_DEFINES_SVH

`ifndef SYNTHESIS
`define RGF_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("remote enable gate check failed");
`define RGF_NEVER(lbl, clk_i, rstn_i, cond) \
	`RGF_ASSERT(lbl, clk_i, rstn_i, !(cond))
`else
`define RGF_ASSERT(lbl, clk_i, rstn_i, prop)
`define RGF_NEVER(lbl, clk_i, rstn_i, cond)
`endif

`endif

// ----- src/regf_pkg.sv -----
// Shared types and constants for the remote enable gate.
// Used by every module of the block; depends on nothing.
`default_nettype none

package regf_pkg;

	localparam int unsigned TimeW = 32;
	localparam logic [TimeW-1:0] SilenceReset = 32'd10000;

	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_ESTOP    = 2'd1,
		MODE_ENABLED  = 2'd2,
		MODE_LINK     = 2'd3
	} regf_mode_t;

	typedef struct packed {
		logic             switch_on;
		logic             estop_active;
		logic             request_seen;
		logic [TimeW-1:0] now_ms;
		logic [TimeW-1:0] last_request_ms;
	} regf_item_t;

	typedef struct packed {
		logic valid;
		logic advance;
	} regf_flow_t;

endpackage

`default_nettype wire

// ----- src/regf_in_stage.sv -----
// Input register of the remote enable gate: holds one accepted tick item.
// Depends on regf_pkg.
`default_nettype none

module regf_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire regf_pkg::regf_item_t in_item,
	input  wire logic              advance,
	output regf_pkg::regf_flow_t   flow,
	output regf_pkg::regf_item_t   item
);
	import regf_pkg::*;

	logic       valid_s1;
	regf_item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign flow.valid   = valid_s1;
	assign flow.advance = advance;
	assign item         = item_s1;

endmodule

`default_nettype wire

// ----- src/regf_core.sv -----
// Gate state machine: mode, entry time and arming flag, updated once per item.
// Depends on regf_pkg and remote_enable_gate_fsm_defines.svh.
`default_nettype none
`include "remote_enable_gate_fsm_defines.svh"

module regf_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire regf_pkg::regf_flow_t          flow,
	input  wire regf_pkg::regf_item_t          item,
	input  wire logic [regf_pkg::TimeW-1:0]    link_timeout_ms,
	output regf_pkg::regf_mode_t               result
);
	import regf_pkg::*;

	regf_mode_t       mode_q, mode_d;
	logic [TimeW-1:0] entry_q, entry_d;
	logic             armed_q, armed_d;

	logic             alive;
	logic             reenter;
	logic [TimeW-1:0] entry_eff;
	logic             arm_base;
	logic             arm_hit;

	assign alive     = item.request_seen &&
		((item.now_ms - item.last_request_ms) < link_timeout_ms);
	assign reenter   = (mode_q != MODE_ENABLED);
	assign entry_eff = reenter ? item.now_ms : entry_q;
	assign arm_base  = reenter ? alive : armed_q;
	assign arm_hit   = item.request_seen &&
		((item.last_request_ms - entry_eff) <= (item.now_ms - entry_eff));

	always_comb begin
		mode_d  = mode_q;
		entry_d = entry_q;
		armed_d = armed_q;
		priority if (!item.switch_on) begin
			mode_d  = MODE_DISABLED;
			armed_d = 1'b0;
		end else if (item.estop_active) begin
			mode_d = MODE_ESTOP;
		end else if (mode_q == MODE_LINK && !alive) begin
			mode_d = MODE_LINK;
		end else begin
			entry_d = entry_eff;
			armed_d = arm_base || arm_hit;
			mode_d  = (armed_d && !alive) ? MODE_LINK : MODE_ENABLED;
		end
	end

	assign result = mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_DISABLED;
			entry_q <= '0;
			armed_q <= 1'b0;
		end else if (flow.advance) begin
			mode_q  <= mode_d;
			entry_q <= entry_d;
			armed_q <= armed_d;
		end
	end

	`RGF_ASSERT(a_switch_off_clears, clk, arst_n, flow.advance && !item.switch_on |=> mode_q == MODE_DISABLED && !armed_q)
	`RGF_ASSERT(a_estop_mode, clk, arst_n, flow.advance && item.switch_on && item.estop_active |=> mode_q == MODE_ESTOP)
	`RGF_NEVER(a_link_needs_arm, clk, arst_n, mode_q == MODE_LINK && !armed_q)
	`RGF_ASSERT(a_state_holds_idle, clk, arst_n, !flow.advance |=> $stable(entry_q) && $stable(mode_q) && $stable(armed_q))

endmodule

`default_nettype wire

// ----- src/regf_out_stage.sv -----
// Result register of the remote enable gate: holds gate_state until taken.
// Depends on regf_pkg.
`default_nettype none

module regf_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire regf_pkg::regf_mode_t result,
	output logic                      advance,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                gate_state
);
	import regf_pkg::*;

	logic       valid_s2;
	regf_mode_t state_s2;

	assign advance = in_valid && (!valid_s2 || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s2 <= result;
		end
	end

	assign out_valid  = valid_s2;
	assign gate_state = state_s2;

endmodule

`default_nettype wire

// ----- src/remote_enable_gate_fsm.sv -----
// Top level of the remote enable gate: config register, input and result stages.
// Depends on regf_pkg, regf_in_stage, regf_core and regf_out_stage.
//
//   channel | signals                                            | direction
//   tick    | in_valid/in_ready, switch_on .. last_request_ms    | in
//   gate    | out_valid/out_ready, gate_state                    | out
//   config  | cfg_valid/cfg_ready, link_timeout_ms               | in
//
// One tick item is taken every clock cycle while the result register is not stalled.
// It is held in the input register, then its gate_state is loaded into the result register,
// from which it can be taken. The state update is one pass of compare logic on the input
// register, so one item per cycle unless the result register is stalled.
// Reset clears the mode, entry time and arming flag and loads a timeout of 10000 ms.
// A stalled result register holds the input register, which then stops taking items.
`default_nettype none

module remote_enable_gate_fsm (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       switch_on,
	input  wire logic                       estop_active,
	input  wire logic                       request_seen,
	input  wire logic [regf_pkg::TimeW-1:0] now_ms,
	input  wire logic [regf_pkg::TimeW-1:0] last_request_ms,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      gate_state,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [regf_pkg::TimeW-1:0] link_timeout_ms
);
	import regf_pkg::*;

	logic [TimeW-1:0] silence_q;
	regf_item_t       in_item;
	regf_item_t       item;
	regf_flow_t       flow;
	regf_mode_t       result;
	logic             advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q <= SilenceReset;
		end else if (cfg_valid && cfg_ready) begin
			silence_q <= link_timeout_ms;
		end
	end

	assign in_item.switch_on       = switch_on;
	assign in_item.estop_active    = estop_active;
	assign in_item.request_seen    = request_seen;
	assign in_item.now_ms          = now_ms;
	assign in_item.last_request_ms = last_request_ms;

	regf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.flow     (flow),
		.item     (item)
	);

	regf_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.flow            (flow),
		.item            (item),
		.link_timeout_ms (silence_q),
		.result          (result)
	);

	regf_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (flow.valid),
		.result     (result),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.gate_state (gate_state)
	);

endmodule

`default_nettype wire
